>>> rtl/ext_tmr_pkg.sv
// Package for the extended timer with alarm: word types and reset constants.
// No dependencies; used by ext_tmr_core and extended_timer_with_alarm.
`default_nettype none

package ext_tmr_pkg;

  // item codes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  // reset values
  localparam logic [31:0] LATE_OFFSET_RST = 32'd1000;
  localparam logic [31:0] COMPARE_RST     = 32'hFFFF_FFFF;

  // input word
  typedef struct packed {
    logic        mode;
    logic [63:0] wake_time;
  } tmr_item_t;

  // result word
  typedef struct packed {
    logic [63:0] current_time;
    logic        alarm_fired;
    logic        alarm_active;
    logic [63:0] alarm_readback;
  } tmr_result_t;

endpackage

`default_nettype wire

>>> rtl/extended_timer_with_alarm.sv
// Top level of the 64-bit timer with compare alarm: input and result registers.
// Depends on ext_tmr_pkg and ext_tmr_core.
//
//   port group | direction | handshake          | payload
//   in_*       | input     | in_valid/in_stall  | tmr_item_t (mode, wake_time)
//   out_*      | output    | out_valid/out_stall| tmr_result_t
//   cfg_*      | input     | cfg_valid/cfg_ready| late_alarm_offset, 32 bit
//
// One word per cycle sustained while out_stall is low; an accepted word waits in
// the input register, then moves into the result register, where it can be taken.
// The timer state updates in the same cycle a word leaves the input register.
// Reset is synchronous, active low; time, alarm and offset return to defaults.
// out_stall holds the result register; in_stall rises only when the input
// register holds a word that the full result register cannot take.
// cfg_ready is always high; a write takes effect on the next cycle.
`default_nettype none

module extended_timer_with_alarm
  import ext_tmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire tmr_item_t   in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output tmr_result_t      out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic        in_valid_r;
  tmr_item_t   in_data_r;
  logic        out_valid_r;
  tmr_result_t out_data_r;
  tmr_result_t res;
  logic        out_free;
  logic        step_en;
  logic        in_take;

  // flow control
  assign out_free  = !out_valid_r || !out_stall;
  assign step_en   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  ext_tmr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_data_r),
    .cfg_we    (cfg_valid),
    .cfg_wdata (cfg_data),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/ext_tmr_core.sv
// Timer state, alarm compare logic and the late-offset register.
// Depends on ext_tmr_pkg; instantiated by extended_timer_with_alarm.
`default_nettype none

module ext_tmr_core
  import ext_tmr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire tmr_item_t   item,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output tmr_result_t      res
);

  logic [31:0] late_offset_r;
  logic [31:0] low_count_r, low_count_nxt;
  logic [31:0] epoch_r, epoch_nxt;
  logic [63:0] stored_alarm_r, stored_alarm_nxt;
  logic        alarm_armed_r, alarm_armed_nxt;
  logic [31:0] compare_r, compare_nxt;
  logic        compare_en_r, compare_en_nxt;
  logic        fired;
  logic [31:0] low_inc;
  logic [31:0] late_cmp;
  logic [31:0] alarm_hi;
  logic [31:0] alarm_lo;

  assign low_inc  = low_count_r + 32'd1;
  assign late_cmp = low_count_r + late_offset_r;
  assign alarm_hi = item.wake_time[63:32];
  assign alarm_lo = item.wake_time[31:0];

  // next state for one word, then the match check
  always_comb begin
    low_count_nxt    = low_count_r;
    epoch_nxt        = epoch_r;
    stored_alarm_nxt = stored_alarm_r;
    alarm_armed_nxt  = alarm_armed_r;
    compare_nxt      = compare_r;
    compare_en_nxt   = compare_en_r;
    fired            = 1'b0;

    if (item.mode == MODE_TICK) begin
      low_count_nxt = low_inc;
      if (low_inc == '0) begin
        epoch_nxt = epoch_r + 32'd1;
        if (alarm_armed_r && (epoch_nxt == stored_alarm_r[63:32])) begin
          compare_nxt    = stored_alarm_r[31:0];
          compare_en_nxt = 1'b1;
        end
      end
    end else begin
      stored_alarm_nxt = item.wake_time;
      alarm_armed_nxt  = 1'b1;
      if (epoch_r == alarm_hi) begin
        compare_nxt    = (alarm_lo < low_count_r) ? late_cmp : alarm_lo;
        compare_en_nxt = 1'b1;
      end else begin
        compare_en_nxt = 1'b0;
      end
    end

    // alarm fires once and disarms
    if (compare_en_nxt && (low_count_nxt == compare_nxt)) begin
      compare_en_nxt  = 1'b0;
      alarm_armed_nxt = 1'b0;
      fired           = 1'b1;
    end
  end

  // result word
  assign res.current_time   = {epoch_nxt, low_count_nxt};
  assign res.alarm_fired    = fired;
  assign res.alarm_active   = alarm_armed_nxt;
  assign res.alarm_readback = stored_alarm_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_count_r    <= '0;
      epoch_r        <= '0;
      stored_alarm_r <= '0;
      alarm_armed_r  <= 1'b0;
      compare_r      <= COMPARE_RST;
      compare_en_r   <= 1'b0;
    end else if (step_en) begin
      low_count_r    <= low_count_nxt;
      epoch_r        <= epoch_nxt;
      stored_alarm_r <= stored_alarm_nxt;
      alarm_armed_r  <= alarm_armed_nxt;
      compare_r      <= compare_nxt;
      compare_en_r   <= compare_en_nxt;
    end
  end

  // late offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      late_offset_r <= LATE_OFFSET_RST;
    end else if (cfg_we) begin
      late_offset_r <= cfg_wdata;
    end
  end

  // checks
  a_compare_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    compare_en_r |-> alarm_armed_r)
    else $error("compare enabled without an armed alarm");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.mode == MODE_TICK) |=>
      low_count_r == 32'($past(low_count_r) + 32'd1))
    else $error("tick did not advance the low count");

  a_set_stores: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.mode == MODE_SET) |=>
      (stored_alarm_r == $past(item.wake_time)) && $stable(low_count_r))
    else $error("alarm set did not store the alarm or moved time");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(low_count_r) && $stable(epoch_r) && $stable(alarm_armed_r))
    else $error("timer state changed without a word");

endmodule

`default_nettype wire

>>> verif/extended_timer_with_alarm_test.sv
// Testbench for extended_timer_with_alarm: random and directed tick and alarm words,
// self-checked against an in-bench timer predictor held in a small scoreboard class.
// Depends on ext_tmr_pkg and the extended_timer_with_alarm RTL.
`timescale 1ns / 1ps

module extended_timer_with_alarm_test;
  import ext_tmr_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  // expected timer results, computed at input acceptance
  class timer_scoreboard;
    logic [31:0] late_offset;
    logic [31:0] low_count;
    logic [31:0] epoch;
    logic [63:0] alarm_at;
    logic        armed;
    logic [31:0] compare_value;
    logic        compare_on;
    tmr_result_t results_due[$];
    int          errors;
    int          checked;
    int          fires;

    function new();
      late_offset   = LATE_OFFSET_RST;
      low_count     = '0;
      epoch         = '0;
      alarm_at      = '0;
      armed         = 1'b0;
      compare_value = COMPARE_RST;
      compare_on    = 1'b0;
      errors        = 0;
      checked       = 0;
      fires         = 0;
    endfunction

    function logic [63:0] now();
      return {epoch, low_count};
    endfunction

    // advance the timer by one accepted word and queue its result
    function void note_word(tmr_item_t w);
      tmr_result_t r;
      logic        fired;
      fired = 1'b0;
      if (w.mode == MODE_TICK) begin
        low_count = low_count + 32'd1;
        if (low_count == 32'd0) begin
          epoch = epoch + 32'd1;
          if (armed && epoch == alarm_at[63:32]) begin
            compare_value = alarm_at[31:0];
            compare_on    = 1'b1;
          end
        end
      end else begin
        alarm_at = w.wake_time;
        armed    = 1'b1;
        if (epoch == w.wake_time[63:32]) begin
          // low half already passed: place the compare ahead by the offset
          if (w.wake_time[31:0] < low_count)
            compare_value = low_count + late_offset;
          else
            compare_value = w.wake_time[31:0];
          compare_on = 1'b1;
        end else begin
          compare_on = 1'b0;
        end
      end
      // match is checked after every word, ticks and sets alike
      if (compare_on && low_count == compare_value) begin
        compare_on = 1'b0;
        armed      = 1'b0;
        fired      = 1'b1;
        fires++;
      end
      r.current_time   = {epoch, low_count};
      r.alarm_fired    = fired;
      r.alarm_active   = armed;
      r.alarm_readback = alarm_at;
      results_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(tmr_result_t got);
      tmr_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = results_due.pop_front();
      checked++;
      compare_field("current_time", want.current_time, got.current_time);
      compare_field("alarm_fired", 64'(want.alarm_fired), 64'(got.alarm_fired));
      compare_field("alarm_active", 64'(want.alarm_active), 64'(got.alarm_active));
      compare_field("alarm_readback", want.alarm_readback, got.alarm_readback);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  tmr_item_t   in_data;
  logic        out_valid;
  logic        out_stall;
  tmr_result_t out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  timer_scoreboard board;
  int   words_sent;
  int   holds_asked;
  int   holds_done;
  int   hold_left;
  int   idle_cycles;
  logic quiet;
  logic no_gaps;

  extended_timer_with_alarm i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // result side: check accepted words, random stalls and the long hold-off
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      board.check_result(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 10);
    end
  end

  // watchdog on cycles without any accepted word or taken result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // offer one word and hold it until accepted, then maybe idle
  task automatic send_word(input tmr_item_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
    words_sent++;
    if (!quiet && !no_gaps && $urandom_range(99) < 4) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    tmr_item_t w;
    w.mode      = MODE_TICK;
    w.wake_time = {$urandom, $urandom};
    send_word(w);
  endtask

  task automatic send_alarm(input logic [63:0] at);
    tmr_item_t w;
    w.mode      = MODE_SET;
    w.wake_time = at;
    send_word(w);
  endtask

  // mostly ticks; alarm sets near, behind or at the current time, plus noise
  function automatic tmr_item_t random_word();
    tmr_item_t   w;
    logic [63:0] t;
    int          pick;
    t           = board.now();
    pick        = $urandom_range(99);
    w.mode      = MODE_TICK;
    w.wake_time = {$urandom, $urandom};
    if (pick >= 70) begin
      w.mode = MODE_SET;
      if (pick < 83)
        w.wake_time = t + 64'($urandom_range(0, 12));
      else if (pick < 91)
        w.wake_time = {t[63:32], 32'($urandom_range(0, t[31:0]))};
      else if (pick < 95)
        w.wake_time = t;
    end
    return w;
  endfunction

  // stop offering and wait until every result is back
  task automatic finish_outstanding();
    in_valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure_offset(input logic [31:0] value);
    finish_outstanding();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.late_offset = value;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count, input int hold_at);
    int i;
    for (i = 0; i < count; i++) begin
      // long hold-off on the result side while words keep coming
      if (i == hold_at) begin
        holds_asked++;
        no_gaps = 1'b1;
      end
      if (i == hold_at + 80)
        no_gaps = 1'b0;
      send_word(random_word());
    end
    no_gaps = 1'b0;
  endtask

  task automatic run_directed();
    logic [63:0] t;
    send_tick();
    send_tick();
    // low half already passed, compare placed offset ahead
    send_alarm(64'd0);
    // all ones lies in another epoch and stays armed
    send_alarm('1);
    // exactly the current time fires on the same word
    send_alarm(board.now());
    // two ticks ahead fires on the second tick
    send_alarm(board.now() + 64'd2);
    send_tick();
    send_tick();
    // a pending alarm replaced by a nearer one
    send_alarm(board.now() + 64'd3);
    send_alarm(board.now() + 64'd1);
    send_tick();
    send_tick();
    send_tick();
    // next epoch keeps the compare off
    t = board.now();
    send_alarm({32'd1, t[31:0]});
    send_tick();
    send_alarm(64'h8000_0000_0000_0000);
    send_alarm({32'd0, 32'hFFFF_FFFF});
    send_alarm(64'h5555_5555_AAAA_AAAA);
    send_alarm(64'hAAAA_AAAA_5555_5555);
    send_tick();
  endtask

  initial begin
    logic [31:0] offsets [5];
    int          p;
    board       = new();
    words_sent  = 0;
    holds_asked = 0;
    holds_done  = 0;
    hold_left   = 0;
    idle_cycles = 0;
    quiet       = 1'b0;
    no_gaps     = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    offsets     = '{32'd0, 32'd6, 32'hFFFF_FFFF, 32'($urandom_range(1, 40)), 32'd1};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset offset first, then one phase per offset setting
    run_directed();
    random_phase(100, -1);
    for (p = 0; p < 5; p++) begin
      configure_offset(offsets[p]);
      quiet = (p == 1);
      random_phase(130, (p == 2) ? 20 : -1);
    end
    quiet = 1'b0;
    finish_outstanding();

    $display("Summary: %0d words sent, %0d results checked, %0d alarms fired",
             words_sent, board.checked, board.fires);
    $display("Offsets: reset value, 0, 6, all ones, 1 and one random; one long hold-off");
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
